// File: design/lfb_pkg.sv
// Shared types and constants of the LED fade and blink controller.
`default_nettype none
package lfb_pkg;

   localparam int LEVEL_W   = 8;
   localparam int PIN_W     = 8;
   localparam int TIME_W    = 15;
   localparam int ELAPSED_W = 16;
   localparam int SCALE_W   = 9;
   localparam int QUOT_W    = 8;
   localparam int FUNC_W    = 3;
   localparam int MODE_W    = 3;
   localparam int CSR_IDX_W = 2;

   localparam logic [LEVEL_W-1:0]   LEVEL_FULL  = 8'd255;
   localparam logic [LEVEL_W-1:0]   LEVEL_DARK  = 8'd0;
   localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = 16'hFFFF;
   localparam logic [SCALE_W-1:0]   SCALE_FULL  = 9'd256;

   localparam logic [PIN_W-1:0]  RST_LED_PIN   = 8'd0;
   localparam logic [TIME_W-1:0] RST_FADE_TIME = 15'd1000;
   localparam logic [TIME_W-1:0] RST_BLINK_ON  = 15'd500;
   localparam logic [TIME_W-1:0] RST_BLINK_OFF = 15'd500;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_TICK     = 3'd0,
      FUNC_ON       = 3'd1,
      FUNC_OFF      = 3'd2,
      FUNC_TOGGLE   = 3'd3,
      FUNC_FADE_IN  = 3'd4,
      FUNC_FADE_OUT = 3'd5,
      FUNC_BLINK    = 3'd6
   } func_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_OFF      = 3'd0,
      MODE_ON       = 3'd1,
      MODE_FADE_IN  = 3'd2,
      MODE_FADE_OUT = 3'd3,
      MODE_BLINK    = 3'd4
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCALE,
      ST_DIVIDE,
      ST_MULT,
      ST_LEVEL,
      ST_EMIT
   } state_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LED_PIN   = 2'd0,
      CSR_FADE_TIME = 2'd1,
      CSR_BLINK_ON  = 2'd2,
      CSR_BLINK_OFF = 2'd3
   } csr_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage
`default_nettype wire

// File: design/lfb_scale_div.sv
// Iterative restoring divider producing the eight-bit fade scale, one bit per cycle.
`default_nettype none
module lfb_scale_div (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [lfb_pkg::TIME_W-1:0] dividend,
   input  wire logic [lfb_pkg::TIME_W-1:0] divisor,
   output logic      [lfb_pkg::QUOT_W-1:0] quotient,
   output lfb_pkg::div_stat_type           stat
);
   import lfb_pkg::*;

   localparam int CNT_W = $clog2(QUOT_W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QUOT_W - 1);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [TIME_W-1:0]   rem_ff, rem_in;
   logic [QUOT_W-1:0]   quot_ff, quot_in;

   logic [TIME_W:0]     shifted;
   logic [TIME_W:0]     diff;
   logic                ge;

   // The remainder always stays below the divisor, so one doubling fits in TIME_W+1 bits.
   always_comb begin
      shifted = {rem_ff, 1'b0};
      diff    = shifted - {1'b0, divisor};
      ge      = shifted >= {1'b0, divisor};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quot_in = quot_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = dividend;
         quot_in = '0;
      end else if (busy_ff) begin
         rem_in  = ge ? diff[TIME_W-1:0] : shifted[TIME_W-1:0];
         quot_in = {quot_ff[QUOT_W-2:0], ge};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
   end

   assign quotient = quot_ff;
   assign stat     = {busy_ff, done_ff};

`ifndef SYNTHESIS
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("divider reports done while still busy");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff)
      else $error("divider not busy after start");

   a_done_after_last: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff) && $past(cnt_ff) == CNT_LAST)
      else $error("divider done without completing all steps");
`endif

endmodule
`default_nettype wire

// File: design/led_fade_blink_controller_top.sv
// Top level of the LED fade and blink controller: sequencer, state and result register.
`default_nettype none
// Each transfer on the req_ channel is a one-millisecond tick or a command, and
// produces exactly one rsp_ transfer carrying the LED level and mode after it.
// Commands, and ticks outside a fade, pass from idle through the emit step, which
// loads their result. A tick during a fade goes from idle through the scale step,
// which starts the eight-step restoring divider that forms the fade scale
// elapsed*256/fade_time (one quotient bit per cycle), the divide step, which
// collects the quotient, then a multiply step, a curve step and the emit step.
// Where elapsed has reached fade_time the divider is skipped and the tick goes
// straight from the scale step to the multiply step. A result still waiting in the
// output register stretches an item by the cycles it waits there.
// req_ready is high whenever the sequencer is idle, even while a result still
// waits in the output register. Configuration writes are taken on any cycle in
// which csr_we is high and should be made only while the block is idle.
module led_fade_blink_controller_top (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [lfb_pkg::FUNC_W-1:0]    req_func,
   input  wire logic [lfb_pkg::PIN_W-1:0]     req_target_pin,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic      [lfb_pkg::LEVEL_W-1:0]   rsp_level,
   output logic      [lfb_pkg::MODE_W-1:0]    rsp_mode,
   input  wire logic                          csr_we,
   input  wire logic [lfb_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [lfb_pkg::TIME_W-1:0]    csr_wdata
);
   import lfb_pkg::*;

   localparam int PROD_W = 17;
   localparam int WIDE_W = PROD_W + LEVEL_W;
   localparam logic [SCALE_W:0] SCALE_TWICE = 10'd512;

   state_type            state_ff, state_in;
   mode_type             mode_ff, mode_in;
   logic [LEVEL_W-1:0]   level_ff, level_in;
   logic [ELAPSED_W-1:0] elapsed_ff, elapsed_in;
   logic [SCALE_W-1:0]   scale_ff, scale_in;
   logic [PROD_W-1:0]    prod_ff, prod_in;

   logic [PIN_W-1:0]     led_pin_ff;
   logic [TIME_W-1:0]    fade_time_ff;
   logic [TIME_W-1:0]    blink_on_ff;
   logic [TIME_W-1:0]    blink_off_ff;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_W-1:0]   rsp_level_ff, rsp_level_in;
   logic [MODE_W-1:0]    rsp_mode_ff, rsp_mode_in;

   logic                 div_start;
   logic [QUOT_W-1:0]    div_quot;
   div_stat_type         div_stat;

   func_type             func;
   logic                 pin_hit;
   logic [ELAPSED_W-1:0] elapsed_inc;
   logic [TIME_W-1:0]    divisor;
   logic                 fading_in;
   logic [SCALE_W:0]     mul_b;
   logic [PROD_W-1:0]    mul_a_ext, mul_b_ext;
   logic [WIDE_W-1:0]    wide;
   logic [LEVEL_W-1:0]   curve;
   logic [LEVEL_W-1:0]   fade_level;
   logic                 fade_over;

   lfb_scale_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (elapsed_ff[TIME_W-1:0]),
      .divisor  (divisor),
      .quotient (div_quot),
      .stat     (div_stat)
   );

   always_comb begin
      func        = func_type'(req_func);
      pin_hit     = req_target_pin == led_pin_ff;
      elapsed_inc = (elapsed_ff == ELAPSED_MAX) ? elapsed_ff : elapsed_ff + 1'b1;
      // A zero fade time divides by one, so the fade completes on its first tick.
      divisor     = (fade_time_ff == '0) ? TIME_W'(1) : fade_time_ff;
      fading_in   = mode_ff == MODE_FADE_IN;
      mul_b       = fading_in ? {1'b0, scale_ff} : SCALE_TWICE - {1'b0, scale_ff};
      mul_a_ext   = PROD_W'(scale_ff);
      mul_b_ext   = PROD_W'(mul_b);
      // 255*p is formed as 256*p - p; the product never exceeds 65536.
      wide        = {prod_ff, {LEVEL_W{1'b0}}} - WIDE_W'(prod_ff);
      curve       = wide[2*LEVEL_W+LEVEL_W-1:2*LEVEL_W];
      fade_level  = fading_in ? curve : LEVEL_FULL - curve;
      fade_over   = elapsed_ff > {1'b0, fade_time_ff};
   end

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      level_in     = level_ff;
      elapsed_in   = elapsed_ff;
      scale_in     = scale_ff;
      prod_in      = prod_ff;
      div_start    = 1'b0;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_level_in = rsp_level_ff;
      rsp_mode_in  = rsp_mode_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = ST_EMIT;
               case (func)
                  FUNC_TICK: begin
                     elapsed_in = elapsed_inc;
                     if (mode_ff == MODE_FADE_IN || mode_ff == MODE_FADE_OUT) begin
                        state_in = ST_SCALE;
                     end else if (mode_ff == MODE_BLINK) begin
                        if (level_ff == LEVEL_FULL && elapsed_inc > {1'b0, blink_on_ff}) begin
                           level_in   = LEVEL_DARK;
                           elapsed_in = '0;
                        end else if (level_ff == LEVEL_DARK &&
                                     elapsed_inc > {1'b0, blink_off_ff}) begin
                           level_in   = LEVEL_FULL;
                           elapsed_in = '0;
                        end
                     end
                  end
                  FUNC_ON: begin
                     if (pin_hit) begin
                        level_in = LEVEL_FULL;
                        mode_in  = MODE_ON;
                     end
                  end
                  FUNC_OFF: begin
                     if (pin_hit) begin
                        level_in = LEVEL_DARK;
                        mode_in  = MODE_OFF;
                     end
                  end
                  FUNC_TOGGLE: begin
                     if (pin_hit) begin
                        if (level_ff == LEVEL_FULL) begin
                           level_in = LEVEL_DARK;
                           mode_in  = MODE_OFF;
                        end else begin
                           level_in = LEVEL_FULL;
                           mode_in  = MODE_ON;
                        end
                     end
                  end
                  FUNC_FADE_IN: begin
                     if (pin_hit && mode_ff == MODE_OFF) begin
                        elapsed_in = '0;
                        mode_in    = MODE_FADE_IN;
                     end
                  end
                  FUNC_FADE_OUT: begin
                     if (pin_hit && mode_ff == MODE_ON) begin
                        elapsed_in = '0;
                        mode_in    = MODE_FADE_OUT;
                     end
                  end
                  FUNC_BLINK: begin
                     if (pin_hit) begin
                        level_in   = LEVEL_FULL;
                        elapsed_in = '0;
                        mode_in    = MODE_BLINK;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCALE: begin
            // Once elapsed reaches the divisor the scale saturates at full.
            if (elapsed_ff >= {1'b0, divisor}) begin
               scale_in = SCALE_FULL;
               state_in = ST_MULT;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_stat.done) begin
               scale_in = {1'b0, div_quot};
               state_in = ST_MULT;
            end
         end
         ST_MULT: begin
            prod_in  = PROD_W'(mul_a_ext * mul_b_ext);
            state_in = ST_LEVEL;
         end
         ST_LEVEL: begin
            level_in = fade_level;
            if (fading_in) begin
               if (fade_level == LEVEL_FULL || fade_over) begin
                  level_in = LEVEL_FULL;
                  mode_in  = MODE_ON;
               end
            end else if (fade_level == LEVEL_DARK || fade_over) begin
               level_in = LEVEL_DARK;
               mode_in  = MODE_OFF;
            end
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            // Wait until the output register is free or is being emptied this cycle.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_level_in = level_ff;
               rsp_mode_in  = mode_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_OFF;
         level_ff     <= LEVEL_DARK;
         elapsed_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         level_ff     <= level_in;
         elapsed_ff   <= elapsed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      scale_ff     <= scale_in;
      prod_ff      <= prod_in;
      rsp_level_ff <= rsp_level_in;
      rsp_mode_ff  <= rsp_mode_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         led_pin_ff   <= RST_LED_PIN;
         fade_time_ff <= RST_FADE_TIME;
         blink_on_ff  <= RST_BLINK_ON;
         blink_off_ff <= RST_BLINK_OFF;
      end else if (csr_we) begin
         case (csr_type'(csr_index))
            CSR_LED_PIN:   led_pin_ff   <= csr_wdata[PIN_W-1:0];
            CSR_FADE_TIME: fade_time_ff <= csr_wdata;
            CSR_BLINK_ON:  blink_on_ff  <= csr_wdata;
            CSR_BLINK_OFF: blink_off_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_level = rsp_level_ff;
   assign rsp_mode  = rsp_mode_ff;

`ifndef SYNTHESIS
   a_div_done_in_divide: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> state_ff == ST_DIVIDE)
      else $error("divider finished outside the divide step");

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EMIT))
      else $error("result loaded outside the emit step");

   a_off_is_dark: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_OFF |-> level_ff == LEVEL_DARK)
      else $error("LED off but level not dark");

   a_on_is_full: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_ON |-> level_ff == LEVEL_FULL)
      else $error("LED on but level not full");
`endif

endmodule
`default_nettype wire
